// File: hw/rtl/gstf_pkg.sv
// Shared types and constants for the gated segment transmit queue.
// Holds status codes, state encodings and the structures passed between stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gstf_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PAYLOAD_BYTES_DEF = 64;

  localparam int SEG_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int REQ_W      = 16;
  localparam int LEN_OUT_W  = 7;
  localparam int JOB_SLOT_W = 8;
  localparam int META_W     = SEG_W + LEN_OUT_W;
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_GRANTED  = 2'd2,
    ST_REFUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FS_IDLE   = 2'b01,
    FS_LOOKUP = 2'b10
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE   = 2'b01,
    BS_STREAM = 2'b10
  } back_state_t;

  typedef struct packed {
    logic                  stream;
    status_t               status;
    logic [SEG_W-1:0]      seg;
    logic [JOB_SLOT_W-1:0] slot;
    logic [LEN_OUT_W-1:0]  n;
  } job_t;

  typedef struct packed {
    status_t              status;
    logic [SEG_W-1:0]     seg;
    logic [BYTE_W-1:0]    data;
    logic                 valid;
    logic [LEN_OUT_W-1:0] len;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/gstf_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module gstf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/gstf_front.sv
// Front stage: accepts items, fills payload slots, commits and releases entries.
// Depends on gstf_pkg and gstf_ram (entry metadata store).
`timescale 1ns / 1ps
`default_nettype none

module gstf_front #(
  parameter int QUEUE_DEPTH   = gstf_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = gstf_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         push,
  output logic                                              full,
  input  wire logic                                         command,
  input  wire logic [gstf_pkg::BYTE_W-1:0]                  data_byte,
  input  wire logic                                         byte_valid,
  input  wire logic                                         last_byte,
  input  wire logic [gstf_pkg::SEG_W-1:0]                   segment_number,
  input  wire logic [gstf_pkg::SEG_W-1:0]                   max_segment,
  input  wire logic [gstf_pkg::REQ_W-1:0]                   requested_length,
  output logic                                              jq_push,
  output gstf_pkg::job_t                                    jq_job,
  input  wire logic                                         jq_full,
  input  wire logic                                         stream_done,
  output logic                                              pay_we,
  output logic [$clog2(QUEUE_DEPTH*PAYLOAD_BYTES)-1:0]      pay_addr,
  output logic [gstf_pkg::BYTE_W-1:0]                       pay_data
);
  import gstf_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W = $clog2(QUEUE_DEPTH * PAYLOAD_BYTES);
  localparam int GAP_W  = SLOT_W + 4;

  front_state_t      state, state_next;
  logic [SLOT_W-1:0] head_slot, head_slot_next;
  logic [SLOT_W-1:0] tail_slot, tail_slot_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [FILL_W-1:0] fill_position, fill_position_next;
  logic              dropping, dropping_next;
  logic [2:0]        outstanding, outstanding_next;
  logic [SEG_W-1:0]  bound;
  logic [REQ_W-1:0]  req;

  logic              accept;
  logic              queue_full;
  logic              conflict;
  logic [GAP_W-1:0]  gap;
  logic              meta_we;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;
  logic [SEG_W-1:0]  head_seg;
  logic [LEN_OUT_W-1:0] head_len;
  logic [LEN_OUT_W-1:0] grant_n;
  logic [FILL_W-1:0] fill_after;

  gstf_ram #(
    .WIDTH(META_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_meta (
    .clk  (clk),
    .we   (meta_we),
    .waddr(tail_slot),
    .wdata(meta_wdata),
    .raddr(head_slot),
    .rdata(meta_rdata)
  );

  // distance from tail back to head: slots just released but still being read
  always_comb begin
    if (head_slot >= tail_slot) begin
      gap = GAP_W'(head_slot) - GAP_W'(tail_slot);
    end else begin
      gap = GAP_W'(head_slot) + GAP_W'(QUEUE_DEPTH) - GAP_W'(tail_slot);
    end
  end

  assign conflict   = (gap != '0) && (gap <= GAP_W'(outstanding));
  assign full       = (state != FS_IDLE) || jq_full || conflict;
  assign accept     = push && !full;
  assign queue_full = (entry_count == CNT_W'(QUEUE_DEPTH));

  assign pay_we   = accept && !command && byte_valid && !queue_full && !dropping &&
                    (fill_position < FILL_W'(PAYLOAD_BYTES));
  assign pay_addr = ADDR_W'(tail_slot) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(fill_position);
  assign pay_data = data_byte;

  assign fill_after = pay_we ? fill_position + 1'b1 : fill_position;
  assign meta_we    = accept && !command && last_byte && !dropping && !queue_full;
  assign meta_wdata = {segment_number, LEN_OUT_W'(fill_after)};

  assign head_seg = meta_rdata[META_W-1:LEN_OUT_W];
  assign head_len = meta_rdata[LEN_OUT_W-1:0];
  assign grant_n  = (REQ_W'(head_len) <= req) ? head_len : req[LEN_OUT_W-1:0];

  always_comb begin
    state_next         = state;
    head_slot_next     = head_slot;
    tail_slot_next     = tail_slot;
    entry_count_next   = entry_count;
    fill_position_next = fill_position;
    dropping_next      = dropping;
    outstanding_next   = outstanding - {2'b00, stream_done};
    jq_push            = 1'b0;
    jq_job             = '{stream: 1'b0, status: ST_REFUSED, seg: '0, slot: '0, n: '0};
    case (state)
      FS_IDLE: begin
        if (accept && !command) begin
          fill_position_next = fill_after;
          if (byte_valid && queue_full) begin
            dropping_next = 1'b1;
          end
          if (last_byte) begin
            jq_push = 1'b1;
            fill_position_next = '0;
            dropping_next = 1'b0;
            if (dropping || queue_full) begin
              jq_job.status = ST_DROPPED;
            end else begin
              jq_job.status    = ST_ENQUEUED;
              tail_slot_next   = (tail_slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                 : tail_slot + 1'b1;
              entry_count_next = entry_count + 1'b1;
            end
          end
        end else if (accept && command) begin
          if (entry_count == '0) begin
            jq_push = 1'b1;
          end else begin
            state_next = FS_LOOKUP;
          end
        end
      end
      FS_LOOKUP: begin
        state_next = FS_IDLE;
        jq_push    = 1'b1;
        if (head_seg <= bound) begin
          jq_job.status    = ST_GRANTED;
          jq_job.seg       = head_seg;
          jq_job.slot      = JOB_SLOT_W'(head_slot);
          jq_job.n         = grant_n;
          jq_job.stream    = (grant_n != '0);
          head_slot_next   = (head_slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                             : head_slot + 1'b1;
          entry_count_next = entry_count - 1'b1;
          outstanding_next = outstanding - {2'b00, stream_done} + 3'd1;
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FS_IDLE;
      head_slot     <= '0;
      tail_slot     <= '0;
      entry_count   <= '0;
      fill_position <= '0;
      dropping      <= 1'b0;
      outstanding   <= '0;
    end else begin
      state         <= state_next;
      head_slot     <= head_slot_next;
      tail_slot     <= tail_slot_next;
      entry_count   <= entry_count_next;
      fill_position <= fill_position_next;
      dropping      <= dropping_next;
      outstanding   <= outstanding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && command) begin
      bound <= max_segment;
      req   <= requested_length;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gstf_jobq.sv
// Two-entry job queue between the front and back stages.
// Depends on gstf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gstf_jobq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gstf_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output gstf_pkg::job_t      head_job,
  output logic                empty
);
  import gstf_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gstf_back.sv
// Back stage: turns jobs into result items, streaming payload bytes from the store.
// Depends on gstf_pkg; reads the payload RAM instanced at the top level.
`timescale 1ns / 1ps
`default_nettype none

module gstf_back #(
  parameter int QUEUE_DEPTH   = gstf_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = gstf_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire gstf_pkg::job_t                          jq_job,
  input  wire logic                                    jq_empty,
  output logic                                         jq_pop,
  output logic                                         stream_done,
  output logic [$clog2(QUEUE_DEPTH*PAYLOAD_BYTES)-1:0] pay_raddr,
  input  wire logic [gstf_pkg::BYTE_W-1:0]             pay_rdata,
  output logic                                         empty,
  input  wire logic                                    pop,
  output gstf_pkg::result_t                            head_result
);
  import gstf_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = $clog2(QUEUE_DEPTH * PAYLOAD_BYTES);

  back_state_t          state, state_next;
  logic [SLOT_W-1:0]    slot;
  logic [SEG_W-1:0]     seg;
  logic [LEN_OUT_W-1:0] n;
  logic [LEN_OUT_W-1:0] idx;
  logic                 inflight;
  logic [SEG_W-1:0]     if_seg;
  logic [LEN_OUT_W-1:0] if_n;
  logic                 if_last;

  result_t              oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  oq_wr, oq_rd;
  logic [OQ_CNT_W-1:0]  oq_count;

  logic    room;
  logic    issue;
  logic    issue_last;
  logic    direct_wr;
  logic    load;
  logic    oq_we;
  logic    oq_pop;
  result_t oq_wdata;

  assign room       = ({1'b0, oq_count} + (OQ_CNT_W + 1)'(inflight)) <
                      (OQ_CNT_W + 1)'(OQ_DEPTH);
  assign issue_last = ((idx + 1'b1) == n);
  assign pay_raddr  = ADDR_W'(slot) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(idx);

  always_comb begin
    state_next  = state;
    jq_pop      = 1'b0;
    direct_wr   = 1'b0;
    load        = 1'b0;
    issue       = 1'b0;
    stream_done = 1'b0;
    case (state)
      BS_IDLE: begin
        if (!jq_empty) begin
          if (jq_job.stream) begin
            jq_pop     = 1'b1;
            load       = 1'b1;
            state_next = BS_STREAM;
          end else if (!inflight && (oq_count < OQ_CNT_W'(OQ_DEPTH))) begin
            jq_pop      = 1'b1;
            direct_wr   = 1'b1;
            stream_done = (jq_job.status == ST_GRANTED);
          end
        end
      end
      BS_STREAM: begin
        if (room) begin
          issue = 1'b1;
          if (issue_last) begin
            stream_done = 1'b1;
            state_next  = BS_IDLE;
          end
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    if (inflight) begin
      oq_wdata = '{status: ST_GRANTED, seg: if_seg, data: pay_rdata, valid: 1'b1,
                   len: if_n, last: if_last};
    end else begin
      oq_wdata = '{status: jq_job.status, seg: jq_job.seg, data: '0, valid: 1'b0,
                   len: '0, last: 1'b1};
    end
  end

  assign oq_we       = inflight || direct_wr;
  assign oq_pop      = pop && (oq_count != '0);
  assign empty       = (oq_count == '0);
  assign head_result = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BS_IDLE;
      inflight <= 1'b0;
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      state    <= state_next;
      inflight <= issue;
      if (oq_we) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      oq_count <= oq_count + OQ_CNT_W'(oq_we) - OQ_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= jq_job.slot[SLOT_W-1:0];
      seg  <= jq_job.seg;
      n    <= jq_job.n;
      idx  <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
    if (issue) begin
      if_seg  <= seg;
      if_n    <= n;
      if_last <= issue_last;
    end
    if (oq_we) begin
      oq[oq_wr] <= oq_wdata;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gated_segment_transmit_fifo.sv
// Gated segment transmit queue, built on gstf_pkg, gstf_ram, gstf_front, gstf_jobq, gstf_back.
// Dequeue item on a non-empty queue passes a lookup state (metadata read through the
// registered RAM); on an empty one it skips that state. Granted bytes stream at one result
// per cycle while the output queue has room; status-only results go into it directly.
// Input holds in lookup, when the job queue is full or the tail slot is still being read out.
// Synchronous active-high reset empties the queue; the stores need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gated_segment_transmit_fifo #(
  parameter int QUEUE_DEPTH   = gstf_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = gstf_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              command,
  input  wire logic [gstf_pkg::BYTE_W-1:0]       data_byte,
  input  wire logic                              byte_valid,
  input  wire logic                              last_byte,
  input  wire logic [gstf_pkg::SEG_W-1:0]        segment_number,
  input  wire logic [gstf_pkg::SEG_W-1:0]        max_segment,
  input  wire logic [gstf_pkg::REQ_W-1:0]        requested_length,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [1:0]                             status,
  output logic [gstf_pkg::SEG_W-1:0]             segment_out,
  output logic [gstf_pkg::BYTE_W-1:0]            out_byte,
  output logic                                   out_byte_valid,
  output logic [gstf_pkg::LEN_OUT_W-1:0]         actual_length,
  output logic                                   last_result
);
  import gstf_pkg::*;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH * PAYLOAD_BYTES);

  logic              jq_push, jq_full, jq_pop, jq_empty;
  job_t              jq_in, jq_head;
  logic              stream_done;
  logic              pay_we;
  logic [ADDR_W-1:0] pay_waddr, pay_raddr;
  logic [BYTE_W-1:0] pay_wdata, pay_rdata;
  result_t           head_result;

  gstf_front #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .command         (command),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .last_byte       (last_byte),
    .segment_number  (segment_number),
    .max_segment     (max_segment),
    .requested_length(requested_length),
    .jq_push         (jq_push),
    .jq_job          (jq_in),
    .jq_full         (jq_full),
    .stream_done     (stream_done),
    .pay_we          (pay_we),
    .pay_addr        (pay_waddr),
    .pay_data        (pay_wdata)
  );

  gstf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(QUEUE_DEPTH * PAYLOAD_BYTES)
  ) u_payload (
    .clk  (clk),
    .we   (pay_we),
    .waddr(pay_waddr),
    .wdata(pay_wdata),
    .raddr(pay_raddr),
    .rdata(pay_rdata)
  );

  gstf_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .push    (jq_push),
    .push_job(jq_in),
    .full    (jq_full),
    .pop     (jq_pop),
    .head_job(jq_head),
    .empty   (jq_empty)
  );

  gstf_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .jq_job     (jq_head),
    .jq_empty   (jq_empty),
    .jq_pop     (jq_pop),
    .stream_done(stream_done),
    .pay_raddr  (pay_raddr),
    .pay_rdata  (pay_rdata),
    .empty      (empty),
    .pop        (pop),
    .head_result(head_result)
  );

  assign status         = head_result.status;
  assign segment_out    = head_result.seg;
  assign out_byte       = head_result.data;
  assign out_byte_valid = head_result.valid;
  assign actual_length  = head_result.len;
  assign last_result    = head_result.last;

endmodule

`default_nettype wire
